FILE: sv/rps_pkg.sv
// shared types, codes and constants for the route parameter scanner
`timescale 1ns / 1ps

package rps_pkg;

   localparam int POS_W = 9;
   localparam logic [POS_W-1:0] MAX_LEN = 9'd256;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   localparam logic [3:0] ERR_OK            = 4'd0;
   localparam logic [3:0] ERR_COLON_MID     = 4'd1;
   localparam logic [3:0] ERR_BAD_OPT       = 4'd2;
   localparam logic [3:0] ERR_OPT_NOT_END   = 4'd3;
   localparam logic [3:0] ERR_BAD_REST      = 4'd4;
   localparam logic [3:0] ERR_REST_NOT_END  = 4'd5;
   localparam logic [3:0] ERR_UNCLOSED      = 4'd6;
   localparam logic [3:0] ERR_STAR_NOT_END  = 4'd7;
   localparam logic [3:0] ERR_TOO_LONG      = 4'd8;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_COLON    = 3'd1;
   localparam logic [2:0] KIND_BRACKET  = 3'd2;
   localparam logic [2:0] KIND_REST     = 3'd3;
   localparam logic [2:0] KIND_OPT_REST = 3'd4;
   localparam logic [2:0] KIND_STAR     = 3'd5;

   typedef enum logic [12:0] {
      PH_SCAN      = 13'b0000000000001,
      PH_COLON     = 13'b0000000000010,
      PH_BR1       = 13'b0000000000100,
      PH_BRACKET   = 13'b0000000001000,
      PH_OPT_DOTS  = 13'b0000000010000,
      PH_OPT_NAME  = 13'b0000000100000,
      PH_OPT_CLOSE = 13'b0000001000000,
      PH_OPT_TAIL  = 13'b0000010000000,
      PH_REST_DOTS = 13'b0000100000000,
      PH_REST_NAME = 13'b0001000000000,
      PH_REST_TAIL = 13'b0010000000000,
      PH_STAR      = 13'b0100000000000,
      PH_DONE      = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [3:0]       error_code;
      logic [2:0]       kind;
      logic             wildcard_res;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [POS_W-1:0] name_offset;
      logic [POS_W-1:0] name_length;
   } rsp_type;

endpackage

FILE: sv/route_param_scanner.sv
// route parameter scanner: one byte per cycle, one result per pattern
// a result is loaded into the result register when the last byte of its pattern leaves the input register
// throughput: one byte per cycle; a held result only stalls a further last byte
// the scan step is compares and a position counter between input and result registers
// reset: scanner returns to searching at position zero, both stages empty
`timescale 1ns / 1ps

module route_param_scanner import rps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    item_valid;
   req_type item;
   logic    take;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // a last byte needs room in the result register, others go straight through
   assign take = item_valid & (~item.last | ~rsp_valid_ff | ~rsp_stall);

   rps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   rps_scan_core u_scan_core (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && item.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && item.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/rps_in_stage.sv
// input register stage with stall back to the requester
`timescale 1ns / 1ps

module rps_in_stage import rps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    take,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    accept;

   assign req_stall = valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/rps_scan_core.sv
// scanner state and per-byte step logic, result formed on the last byte
`timescale 1ns / 1ps

module rps_scan_core import rps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   phase_type        phase_ff, phase_in, ph;
   logic [POS_W-1:0] position_ff, position_in;
   logic             slash_ff, slash_in, pws;
   logic [POS_W-1:0] marker_ff, marker_in, mk;
   logic [POS_W-1:0] close_ff, close_in, cl;
   logic [1:0]       dot_ff, dot_in, dc;
   logic [3:0]       perr_ff, perr_in, perr;
   logic [2:0]       pkind_ff, pkind_in, pkind;

   logic             in_range;
   logic [POS_W-1:0] len;
   logic             fin_found;
   logic [3:0]       fin_err;
   logic [2:0]       fin_kind;
   logic [POS_W-1:0] fin_close;
   logic [7:0]       c;

   assign c        = item.ch;
   assign in_range = position_ff < MAX_LEN;
   assign len      = position_ff + 9'd1;

   // one step of the marker scan
   always_comb begin
      ph    = phase_ff;
      pws   = slash_ff;
      mk    = marker_ff;
      cl    = close_ff;
      dc    = dot_ff;
      perr  = perr_ff;
      pkind = pkind_ff;
      if (in_range) begin
         case (phase_ff)
            PH_SCAN: begin
               if (c == CH_COLON) begin
                  mk = position_ff;
                  if (!slash_ff) begin
                     ph = PH_DONE; perr = ERR_COLON_MID; pkind = KIND_COLON; cl = '0;
                  end else begin
                     ph = PH_COLON;
                  end
               end else if (c == CH_OPEN) begin
                  mk = position_ff;
                  ph = PH_BR1;
               end else if (c == CH_STAR) begin
                  mk = position_ff;
                  ph = PH_STAR;
               end else begin
                  pws = (c == CH_SLASH);
               end
            end
            PH_COLON: begin
               if (c == CH_SLASH) begin
                  ph = PH_DONE; perr = ERR_OK; pkind = KIND_COLON; cl = position_ff;
               end
            end
            PH_BR1: begin
               if (c == CH_OPEN) begin
                  dc = 2'd0; ph = PH_OPT_DOTS;
               end else if (c == CH_DOT) begin
                  dc = 2'd1; ph = PH_REST_DOTS;
               end else if (c == CH_CLOSE) begin
                  ph = PH_DONE; perr = ERR_OK; pkind = KIND_BRACKET; cl = position_ff;
               end else begin
                  ph = PH_BRACKET;
               end
            end
            PH_BRACKET: begin
               if (c == CH_CLOSE) begin
                  ph = PH_DONE; perr = ERR_OK; pkind = KIND_BRACKET; cl = position_ff;
               end
            end
            PH_OPT_DOTS: begin
               if (c != CH_DOT) begin
                  ph = PH_DONE; perr = ERR_BAD_OPT; pkind = KIND_OPT_REST; cl = '0;
               end else begin
                  dc = dc + 2'd1;
                  if (dc == 2'd3) begin
                     ph = PH_OPT_NAME;
                  end
               end
            end
            PH_OPT_NAME: begin
               if (c == CH_CLOSE) begin
                  cl = position_ff; ph = PH_OPT_CLOSE;
               end
            end
            PH_OPT_CLOSE: begin
               if (c == CH_CLOSE) begin
                  ph = PH_OPT_TAIL;
               end else begin
                  ph = PH_DONE; perr = ERR_BAD_OPT; pkind = KIND_OPT_REST; cl = '0;
               end
            end
            PH_OPT_TAIL: begin
               ph = PH_DONE; perr = ERR_OPT_NOT_END; pkind = KIND_OPT_REST; cl = '0;
            end
            PH_REST_DOTS: begin
               if (c != CH_DOT) begin
                  ph = PH_DONE; perr = ERR_BAD_REST; pkind = KIND_REST; cl = '0;
               end else begin
                  dc = dc + 2'd1;
                  if (dc == 2'd3) begin
                     ph = PH_REST_NAME;
                  end
               end
            end
            PH_REST_NAME: begin
               if (c == CH_CLOSE) begin
                  cl = position_ff; ph = PH_REST_TAIL;
               end
            end
            PH_REST_TAIL: begin
               ph = PH_DONE; perr = ERR_REST_NOT_END; pkind = KIND_REST; cl = '0;
            end
            PH_STAR: begin
               ph = PH_DONE; perr = ERR_STAR_NOT_END; pkind = KIND_STAR; cl = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // closing decision at the end of the pattern
   always_comb begin
      fin_found = 1'b1;
      fin_err   = perr;
      fin_kind  = pkind;
      fin_close = cl;
      case (ph)
         PH_SCAN: begin
            fin_found = 1'b0;
         end
         PH_COLON: begin
            fin_err = ERR_OK; fin_kind = KIND_COLON; fin_close = len;
         end
         PH_BR1, PH_BRACKET: begin
            fin_err = ERR_UNCLOSED; fin_kind = KIND_BRACKET; fin_close = '0;
         end
         PH_OPT_DOTS, PH_OPT_NAME, PH_OPT_CLOSE: begin
            fin_err = ERR_BAD_OPT; fin_kind = KIND_OPT_REST; fin_close = '0;
         end
         PH_OPT_TAIL: begin
            fin_err = ERR_OK; fin_kind = KIND_OPT_REST;
         end
         PH_REST_DOTS, PH_REST_NAME: begin
            fin_err = ERR_BAD_REST; fin_kind = KIND_REST; fin_close = '0;
         end
         PH_REST_TAIL: begin
            fin_err = ERR_OK; fin_kind = KIND_REST;
         end
         PH_STAR: begin
            fin_err = ERR_OK; fin_kind = KIND_STAR; fin_close = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result = '0;
      if (!in_range) begin
         result.error_code = ERR_TOO_LONG;
      end else if (fin_found) begin
         result.found      = 1'b1;
         result.error_code = fin_err;
         result.kind       = fin_kind;
         result.start_pos  = mk;
         if (fin_err == ERR_OK) begin
            case (fin_kind)
               KIND_COLON: begin
                  result.end_pos     = fin_close - 9'd1;
                  result.name_offset = mk + 9'd1;
                  result.name_length = fin_close - mk - 9'd1;
               end
               KIND_BRACKET: begin
                  result.end_pos     = fin_close;
                  result.name_offset = mk + 9'd1;
                  result.name_length = fin_close - mk - 9'd1;
               end
               KIND_REST: begin
                  result.end_pos      = fin_close + 9'd1;
                  result.name_offset  = mk + 9'd4;
                  result.name_length  = fin_close - mk - 9'd4;
                  result.wildcard_res = 1'b1;
               end
               KIND_OPT_REST: begin
                  result.end_pos      = fin_close + 9'd2;
                  result.name_offset  = mk + 9'd5;
                  result.name_length  = fin_close - mk - 9'd5;
                  result.wildcard_res = 1'b1;
               end
               default: begin
                  result.end_pos      = mk + 9'd1;
                  result.name_offset  = mk;
                  result.name_length  = 9'd1;
                  result.wildcard_res = 1'b1;
               end
            endcase
         end
      end
   end

   // the last byte puts every state element back to its reset value
   always_comb begin
      phase_in    = ph;
      position_in = in_range ? len : MAX_LEN;
      slash_in    = pws;
      marker_in   = mk;
      close_in    = cl;
      dot_in      = dc;
      perr_in     = perr;
      pkind_in    = pkind;
      if (item.last) begin
         phase_in    = PH_SCAN;
         position_in = '0;
         slash_in    = 1'b1;
         marker_in   = '0;
         close_in    = '0;
         dot_in      = '0;
         perr_in     = '0;
         pkind_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SCAN;
         position_ff <= '0;
         slash_ff    <= 1'b1;
         marker_ff   <= '0;
         close_ff    <= '0;
         dot_ff      <= '0;
         perr_ff     <= '0;
         pkind_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         slash_ff    <= slash_in;
         marker_ff   <= marker_in;
         close_ff    <= close_in;
         dot_ff      <= dot_in;
         perr_ff     <= perr_in;
         pkind_ff    <= pkind_in;
      end
   end

endmodule

FILE: bench/route_param_scanner_test.sv
// self-checking testbench for the route parameter scanner
`timescale 1ns / 1ps

module route_param_scanner_test;
   import rps_pkg::*;

   // predicts the scan of each pattern and holds the results still to come
   class marker_scoreboard;
      phase_type        scan_ph;
      logic [POS_W-1:0] at_pos, mark_at, close_at;
      logic             after_slash;
      logic [1:0]       dots_seen;
      logic [3:0]       held_err;
      logic [2:0]       held_kind;
      rsp_type          pending_results[$];
      int               failures;
      int               results_checked;
      int               error_results;

      function new();
         failures = 0;
         results_checked = 0;
         error_results = 0;
         restart();
      endfunction

      function void restart();
         scan_ph = PH_SCAN;
         at_pos = '0;
         after_slash = 1'b1;
         mark_at = '0;
         close_at = '0;
         dots_seen = '0;
         held_err = ERR_OK;
         held_kind = KIND_NONE;
      endfunction

      function void settle(logic [3:0] e, logic [2:0] k, logic [POS_W-1:0] c);
         scan_ph = PH_DONE;
         held_err = e;
         held_kind = k;
         close_at = c;
      endfunction

      function void take_byte(req_type r);
         logic [POS_W-1:0] p;
         rsp_type want;
         p = at_pos;
         if (p < MAX_LEN) begin
            case (scan_ph)
               PH_SCAN: begin
                  if (r.ch == CH_COLON) begin
                     mark_at = p;
                     if (!after_slash) settle(ERR_COLON_MID, KIND_COLON, '0);
                     else scan_ph = PH_COLON;
                  end else if (r.ch == CH_OPEN) begin
                     mark_at = p;
                     scan_ph = PH_BR1;
                  end else if (r.ch == CH_STAR) begin
                     mark_at = p;
                     scan_ph = PH_STAR;
                  end else begin
                     after_slash = (r.ch == CH_SLASH);
                  end
               end
               PH_COLON: if (r.ch == CH_SLASH) settle(ERR_OK, KIND_COLON, p);
               PH_BR1: begin
                  if (r.ch == CH_OPEN) begin
                     dots_seen = 2'd0;
                     scan_ph = PH_OPT_DOTS;
                  end else if (r.ch == CH_DOT) begin
                     dots_seen = 2'd1;
                     scan_ph = PH_REST_DOTS;
                  end else if (r.ch == CH_CLOSE) begin
                     settle(ERR_OK, KIND_BRACKET, p);
                  end else begin
                     scan_ph = PH_BRACKET;
                  end
               end
               PH_BRACKET: if (r.ch == CH_CLOSE) settle(ERR_OK, KIND_BRACKET, p);
               PH_OPT_DOTS: begin
                  if (r.ch != CH_DOT) settle(ERR_BAD_OPT, KIND_OPT_REST, '0);
                  else begin
                     dots_seen = dots_seen + 2'd1;
                     if (dots_seen == 2'd3) scan_ph = PH_OPT_NAME;
                  end
               end
               PH_OPT_NAME: begin
                  if (r.ch == CH_CLOSE) begin
                     close_at = p;
                     scan_ph = PH_OPT_CLOSE;
                  end
               end
               PH_OPT_CLOSE: begin
                  if (r.ch == CH_CLOSE) scan_ph = PH_OPT_TAIL;
                  else settle(ERR_BAD_OPT, KIND_OPT_REST, '0);
               end
               PH_OPT_TAIL: settle(ERR_OPT_NOT_END, KIND_OPT_REST, '0);
               PH_REST_DOTS: begin
                  if (r.ch != CH_DOT) settle(ERR_BAD_REST, KIND_REST, '0);
                  else begin
                     dots_seen = dots_seen + 2'd1;
                     if (dots_seen == 2'd3) scan_ph = PH_REST_NAME;
                  end
               end
               PH_REST_NAME: begin
                  if (r.ch == CH_CLOSE) begin
                     close_at = p;
                     scan_ph = PH_REST_TAIL;
                  end
               end
               PH_REST_TAIL: settle(ERR_REST_NOT_END, KIND_REST, '0);
               PH_STAR: settle(ERR_STAR_NOT_END, KIND_STAR, '0);
               default: ;
            endcase
         end
         at_pos = (p < MAX_LEN) ? p + 9'd1 : MAX_LEN;
         if (!r.last) return;

         want = '0;
         if (p >= MAX_LEN) begin
            want.error_code = ERR_TOO_LONG;
         end else if (scan_ph != PH_SCAN) begin
            // end of pattern resolves whatever marker is still open
            case (scan_ph)
               PH_COLON: settle(ERR_OK, KIND_COLON, p + 9'd1);
               PH_BR1, PH_BRACKET: settle(ERR_UNCLOSED, KIND_BRACKET, '0);
               PH_OPT_DOTS, PH_OPT_NAME, PH_OPT_CLOSE:
                  settle(ERR_BAD_OPT, KIND_OPT_REST, '0);
               PH_OPT_TAIL: settle(ERR_OK, KIND_OPT_REST, close_at);
               PH_REST_DOTS, PH_REST_NAME: settle(ERR_BAD_REST, KIND_REST, '0);
               PH_REST_TAIL: settle(ERR_OK, KIND_REST, close_at);
               PH_STAR: settle(ERR_OK, KIND_STAR, '0);
               default: ;
            endcase
            want.found = 1'b1;
            want.error_code = held_err;
            want.kind = held_kind;
            want.start_pos = mark_at;
            if (held_err == ERR_OK) begin
               case (held_kind)
                  KIND_COLON: begin
                     want.end_pos = close_at - 9'd1;
                     want.name_offset = mark_at + 9'd1;
                     want.name_length = close_at - mark_at - 9'd1;
                  end
                  KIND_BRACKET: begin
                     want.end_pos = close_at;
                     want.name_offset = mark_at + 9'd1;
                     want.name_length = close_at - mark_at - 9'd1;
                  end
                  KIND_REST: begin
                     want.end_pos = close_at + 9'd1;
                     want.name_offset = mark_at + 9'd4;
                     want.name_length = close_at - mark_at - 9'd4;
                     want.wildcard_res = 1'b1;
                  end
                  KIND_OPT_REST: begin
                     want.end_pos = close_at + 9'd2;
                     want.name_offset = mark_at + 9'd5;
                     want.name_length = close_at - mark_at - 9'd5;
                     want.wildcard_res = 1'b1;
                  end
                  default: begin
                     want.end_pos = mark_at + 9'd1;
                     want.name_offset = mark_at;
                     want.name_length = 9'd1;
                     want.wildcard_res = 1'b1;
                  end
               endcase
            end
         end
         pending_results.push_back(want);
         restart();
      endfunction

      function string show(rsp_type r);
         return $sformatf("found=%0d err=%0d kind=%0d wild=%0d start=%0d end=%0d off=%0d len=%0d",
                          r.found, r.error_code, r.kind, r.wildcard_res,
                          r.start_pos, r.end_pos, r.name_offset, r.name_length);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("%0t mismatch: %s", $realtime, msg);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         string bad;
         if (pending_results.size() == 0) begin
            flag({"result with none outstanding: ", show(got)});
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (want.error_code != ERR_OK) error_results++;
         bad = "";
         if (got.found !== want.found) bad = {bad, " found"};
         if (got.error_code !== want.error_code) bad = {bad, " error_code"};
         if (got.kind !== want.kind) bad = {bad, " kind"};
         if (got.wildcard_res !== want.wildcard_res) bad = {bad, " wildcard_res"};
         if (got.start_pos !== want.start_pos) bad = {bad, " start_pos"};
         if (got.end_pos !== want.end_pos) bad = {bad, " end_pos"};
         if (got.name_offset !== want.name_offset) bad = {bad, " name_offset"};
         if (got.name_length !== want.name_length) bad = {bad, " name_length"};
         if (bad != "")
            flag({"wrong", bad, "\n   expected ", show(want), "\n   actual   ", show(got)});
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   marker_scoreboard sb = new();

   logic [7:0] pat[$];
   bit         quiet;
   bit         hold_rsp;
   int         patterns_sent;
   int         bytes_sent;

   route_param_scanner dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL route_param_scanner");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (!reset && !quiet && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 5))
         0: return CH_COLON;
         1: return CH_SLASH;
         2: return CH_OPEN;
         3: return CH_DOT;
         4: return CH_CLOSE;
         default: return CH_STAR;
      endcase
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) pat.push_back(s[i]);
   endfunction

   function automatic void add_name(int n);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: pat.push_back(8'(8'h30 + $urandom_range(0, 9)));
            1: pat.push_back(8'h2D);
            default: pat.push_back(8'(8'h61 + $urandom_range(0, 25)));
         endcase
      end
   endfunction

   // builds one pattern: half well-formed markers, some broken, some noise
   function automatic void make_pattern(int nlen);
      int shape, idx;
      pat.delete();
      shape = $urandom_range(0, 9);
      if (shape >= 8) begin
         repeat ($urandom_range(1, 12)) begin
            if (shape == 8) pat.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1) == 0) pat.push_back(special_char());
            else add_name(1);
         end
         return;
      end
      if ($urandom_range(0, 3) == 0 && shape % 5 == 0) begin
         add_text(":");
      end else begin
         repeat ($urandom_range(0, 2)) begin
            add_text("/");
            add_name($urandom_range(1, 5));
         end
         case (shape % 5)
            0: add_text("/:");
            1: add_text("/[");
            2: add_text("/[...");
            3: add_text("/[[...");
            default: add_text("/*");
         endcase
      end
      if (shape % 5 != 4) add_name(nlen);
      case (shape % 5)
         0: if ($urandom_range(0, 1) == 0) begin
            add_text("/");
            add_name($urandom_range(1, 4));
         end
         1: begin
            add_text("]");
            if ($urandom_range(0, 2) == 0) add_name($urandom_range(1, 3));
         end
         2: add_text("]");
         3: add_text("]]");
         default: ;
      endcase
      // broken variants
      if (shape >= 5) begin
         idx = $urandom_range(0, pat.size() - 1);
         case ($urandom_range(0, 3))
            0: pat.insert(idx, special_char());
            1: if (pat.size() > 1) pat.delete(idx);
            2: pat.push_back($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
            default: pat[idx] = 8'($urandom_range(0, 255));
         endcase
      end
   endfunction

   task automatic send_byte(logic [7:0] b, logic is_last);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ch: b, last: is_last};
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.take_byte('{ch: b, last: is_last});
      @(negedge clock);
   endtask

   task automatic send_pattern();
      for (int i = 0; i < pat.size(); i++) send_byte(pat[i], i == pat.size() - 1);
      patterns_sent++;
      bytes_sent += pat.size();
   endtask

   task automatic send_text(string s);
      pat.delete();
      add_text(s);
      send_pattern();
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   initial begin
      string directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      patterns_sent = 0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed = '{"a", ":", "/:id/x", "a:b", "[id]", "[", "[]", "[...all]",
                   "[...all]x", "[..x]", "[[...o]]", "[[...o]]/", "[[..o]]",
                   "[[...o]x", "/a/*", "*b", "/u/:"};
      foreach (directed[i]) send_text(directed[i]);

      // byte extremes with no marker
      pat = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      send_pattern();

      // longest legal pattern ending in an optional wildcard, then a rest wildcard one byte over
      pat.delete();
      add_text("[[...");
      add_name(249);
      add_text("]]");
      send_pattern();
      pat.delete();
      add_text("[...");
      add_name(252);
      add_text("]");
      send_pattern();

      // sender pause until every result is in
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);

      // long receiver hold-off while short patterns keep coming
      hold_rsp = 1'b1;
      repeat (12) begin
         make_pattern($urandom_range(1, 3));
         send_pattern();
      end

      while (bytes_sent < 900) begin
         if (bytes_sent > 800) quiet = 1'b1;
         if ($urandom_range(0, 119) == 0) make_pattern($urandom_range(240, 290));
         else make_pattern($urandom_range(1, 8));
         send_pattern();
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.outstanding() != 0) sb.flag("results still outstanding at end of run");

      $display("covered %0d patterns (%0d bytes) incl. every marker kind, broken forms and",
               patterns_sent, bytes_sent);
      $display("over-length input; %0d results checked, %0d carrying an error code",
               sb.results_checked, sb.error_results);
      if (sb.failures == 0) $display("PASS route_param_scanner");
      else $display("FAIL route_param_scanner");
      $finish;
   end

endmodule
